@@ hdl/page_run_segment_builder_assert.svh @@
// Assertion macros used by the checker file of the segment builder.
// Both macros expect a signal named clk in the calling scope; PRSB_ASSERT also needs rst_n.
`ifndef PAGE_RUN_SEGMENT_BUILDER_ASSERT_SVH
`define PAGE_RUN_SEGMENT_BUILDER_ASSERT_SVH

// Checked only while the block is out of reset.
`define PRSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define PRSB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ hdl/prsb_pkg.sv @@
`default_nettype none

package prsb_pkg;

    localparam int ADDR_W        = 32;
    localparam int IDX_W         = 12;
    localparam int CFG_IDX_W     = 4;
    localparam int PAGE_BITS_DEF = 12;
    localparam int MAX_PAGES_DEF = 4096;
    localparam int FIFO_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIRT_START = 4'd0,
        REG_VIRT_END   = 4'd1
    } cfg_reg_e;

    // One page as it sits in the input register.
    typedef struct packed {
        logic [ADDR_W-1:0] page_phys;
        logic              final_page;
    } page_t;

    // One emitted segment.
    typedef struct packed {
        logic [ADDR_W-1:0] seg_virt_begin;
        logic [ADDR_W-1:0] seg_virt_stop;
        logic [ADDR_W-1:0] seg_phys_begin;
        logic [IDX_W-1:0]  first_page_idx;
        logic [IDX_W-1:0]  last_page_idx;
        logic [IDX_W-1:0]  seg_number;
        logic              final_segment;
    } seg_t;

    // Up to two segments written to the output queue in one cycle.
    // push1 is only ever set together with push0.
    typedef struct packed {
        logic push0;
        logic push1;
        seg_t seg0;
        seg_t seg1;
    } push_t;

endpackage

`default_nettype wire

@@ hdl/prsb_if.sv @@
`default_nettype none

interface prsb_page_if import prsb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] page_phys;
    logic              final_page;

    modport source (output valid, output page_phys, output final_page, input ready);
    modport sink (input valid, input page_phys, input final_page, output ready);
endinterface

interface prsb_seg_if import prsb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] seg_virt_begin;
    logic [ADDR_W-1:0] seg_virt_stop;
    logic [ADDR_W-1:0] seg_phys_begin;
    logic [IDX_W-1:0]  first_page_idx;
    logic [IDX_W-1:0]  last_page_idx;
    logic [IDX_W-1:0]  seg_number;
    logic              final_segment;

    modport source (
        output valid, output seg_virt_begin, output seg_virt_stop, output seg_phys_begin,
        output first_page_idx, output last_page_idx, output seg_number,
        output final_segment, input ready
    );
    modport sink (
        input valid, input seg_virt_begin, input seg_virt_stop, input seg_phys_begin,
        input first_page_idx, input last_page_idx, input seg_number,
        input final_segment, output ready
    );
endinterface

interface prsb_cfg_if import prsb_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    wdata;

    modport source (output valid, output idx, output wdata, input ready);
    modport sink (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

@@ hdl/prsb_in_reg.sv @@
`default_nettype none

// Input register: holds one page until the merge stage consumes it.
module prsb_in_reg import prsb_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    prsb_page_if.sink    pages,
    input  wire logic    advance,
    output logic         s1_valid,
    output page_t        s1_page
);

    logic  valid_reg;
    logic  valid_next;
    page_t page_reg;
    logic  accept;

    assign pages.ready = !valid_reg || advance;
    assign accept      = pages.valid && pages.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg.page_phys  <= pages.page_phys;
            page_reg.final_page <= pages.final_page;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_page  = page_reg;

endmodule

`default_nettype wire

@@ hdl/prsb_merge.sv @@
`default_nettype none

// Contiguity test, segment bookkeeping and segment formatting for one page.
module prsb_merge import prsb_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s1_valid,
    input  wire page_t             s1_page,
    input  wire logic              room,
    input  wire logic [ADDR_W-1:0] virt_start,
    input  wire logic [ADDR_W-1:0] virt_end,
    output logic                   advance,
    output push_t                  push
);

    localparam int                CNT_W      = (MAX_PAGES > 2) ? $clog2(MAX_PAGES) : 1;
    localparam logic [CNT_W-1:0]  LAST_IDX   = CNT_W'(MAX_PAGES - 1);
    localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_BITS;
    localparam logic [ADDR_W-1:0] OFF_MASK   = PAGE_BYTES - ADDR_W'(1);

    logic [ADDR_W-1:0] prev_phys_reg;
    logic [CNT_W-1:0]  page_cnt_reg;
    logic [CNT_W-1:0]  page_cnt_next;
    logic [IDX_W-1:0]  seg_cnt_reg;
    logic [IDX_W-1:0]  seg_cnt_next;
    logic [ADDR_W-1:0] open_virt_reg;
    logic [ADDR_W-1:0] open_virt_next;
    logic [ADDR_W-1:0] open_phys_reg;
    logic [ADDR_W-1:0] open_phys_next;
    logic [IDX_W-1:0]  open_first_reg;
    logic [IDX_W-1:0]  open_first_next;
    logic [IDX_W-1:0]  seg_num_open;

    logic              first_page;
    logic              fin;
    logic              brk;
    logic [ADDR_W-1:0] page_virt;
    seg_t              closed_seg;
    seg_t              final_seg;

    assign advance = s1_valid && room;

    always_comb
    begin
        first_page = (page_cnt_reg == '0);
        fin        = s1_page.final_page || (page_cnt_reg >= LAST_IDX);
        brk        = !first_page && (s1_page.page_phys != prev_phys_reg + PAGE_BYTES);
        page_virt  = (virt_start & ~OFF_MASK) + (ADDR_W'(page_cnt_reg) << PAGE_BITS);

        // Segment that stays open after this page.
        open_virt_next  = open_virt_reg;
        open_phys_next  = open_phys_reg;
        open_first_next = open_first_reg;
        seg_num_open    = seg_cnt_reg;
        if (first_page)
        begin
            open_virt_next  = virt_start;
            open_phys_next  = s1_page.page_phys + (virt_start & OFF_MASK);
            open_first_next = '0;
            seg_num_open    = '0;
        end
        else if (brk)
        begin
            open_virt_next  = page_virt;
            open_phys_next  = s1_page.page_phys;
            open_first_next = IDX_W'(page_cnt_reg);
            seg_num_open    = seg_cnt_reg + IDX_W'(1);
        end

        closed_seg.seg_virt_begin = open_virt_reg;
        closed_seg.seg_virt_stop  = page_virt;
        closed_seg.seg_phys_begin = open_phys_reg;
        closed_seg.first_page_idx = open_first_reg;
        closed_seg.last_page_idx  = IDX_W'(page_cnt_reg - CNT_W'(1));
        closed_seg.seg_number     = seg_cnt_reg;
        closed_seg.final_segment  = 1'b0;

        final_seg.seg_virt_begin = open_virt_next;
        final_seg.seg_virt_stop  = virt_end;
        final_seg.seg_phys_begin = open_phys_next;
        final_seg.first_page_idx = open_first_next;
        final_seg.last_page_idx  = IDX_W'(page_cnt_reg);
        final_seg.seg_number     = seg_num_open;
        final_seg.final_segment  = 1'b1;

        push.push0 = advance && (brk || fin);
        push.push1 = advance && brk && fin;
        push.seg0  = brk ? closed_seg : final_seg;
        push.seg1  = final_seg;

        page_cnt_next = fin ? '0 : page_cnt_reg + CNT_W'(1);
        seg_cnt_next  = fin ? '0 : seg_num_open;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_phys_reg  <= '0;
            page_cnt_reg   <= '0;
            seg_cnt_reg    <= '0;
            open_virt_reg  <= '0;
            open_phys_reg  <= '0;
            open_first_reg <= '0;
        end
        else if (advance)
        begin
            prev_phys_reg  <= s1_page.page_phys;
            page_cnt_reg   <= page_cnt_next;
            seg_cnt_reg    <= seg_cnt_next;
            open_virt_reg  <= open_virt_next;
            open_phys_reg  <= open_phys_next;
            open_first_reg <= open_first_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/prsb_out_fifo.sv @@
`default_nettype none

// Small result queue: takes up to two segments a cycle, hands out one per beat.
module prsb_out_fifo import prsb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    output logic       room,
    prsb_seg_if.source segs
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    seg_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;
    logic [CNT_W-1:0] n_push;
    seg_t             head;

    // Space for two entries is needed before a page may be merged.
    assign room = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign pop  = segs.valid && segs.ready;

    always_comb
    begin
        n_push      = CNT_W'(push.push0) + CNT_W'(push.push1);
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + n_push - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            mem[wr_ptr_reg] <= push.seg0;
        end
        if (push.push1)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.seg1;
        end
    end

    assign head = mem[rd_ptr_reg];

    assign segs.valid          = (count_reg != '0);
    assign segs.seg_virt_begin = head.seg_virt_begin;
    assign segs.seg_virt_stop  = head.seg_virt_stop;
    assign segs.seg_phys_begin = head.seg_phys_begin;
    assign segs.first_page_idx = head.first_page_idx;
    assign segs.last_page_idx  = head.last_page_idx;
    assign segs.seg_number     = head.seg_number;
    assign segs.final_segment  = head.final_segment;

endmodule

`default_nettype wire

@@ hdl/page_run_segment_builder.sv @@
// Page run segment builder. Feed it the physical base address of each page
// of a buffer, one page per beat on the page channel, with final_page set on
// the buffer's last page; it merges pages that follow each other physically
// (each at the previous address plus one page) into segments and sends one
// beat per segment on the segment channel. A segment is closed by the page
// that breaks contiguity and by the final page; a final page that also breaks
// contiguity yields two beats, the closed segment and then a one-page final
// segment. The page with index MAX_PAGES-1 is always treated as final. The
// first segment's physical start includes the in-page offset of virt_start,
// the final segment ends at virt_end, and addresses wrap at 32 bits. Rate: one
// page per clock cycle while the output queue has room; a page waits in an
// input register until it is merged, and its segments are written into a
// four-entry output queue whose head drives the segment channel. A page is
// merged only while the queue has two free entries, so a page that produces
// two segments, or a slow consumer, can hold the page channel.
// The two registers (index 0 virt_start, index 1 virt_end) are written over
// the configuration channel, which is always ready; writes to other indices
// are dropped. Write them only while the block is idle; every page reads
// their current value.
`default_nettype none

module page_run_segment_builder import prsb_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    prsb_cfg_if.sink   cfg,
    prsb_page_if.sink  pages,
    prsb_seg_if.source segs
);

    // Configuration registers.
    logic [ADDR_W-1:0] virt_start_reg;
    logic [ADDR_W-1:0] virt_end_reg;

    // Input register to merge stage.
    logic  s1_valid;
    page_t s1_page;
    logic  advance;

    // Merge stage to output queue.
    push_t push;
    logic  room;

    // The register file never pushes back.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            virt_start_reg <= '0;
            virt_end_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.idx)
                REG_VIRT_START: virt_start_reg <= cfg.wdata;
                REG_VIRT_END:   virt_end_reg   <= cfg.wdata;
                default:        ;
            endcase
        end
    end

    // Holds the accepted page; frees itself in the cycle the merge stage
    // consumes it, so a new page can be taken every cycle while the merge stage keeps up.
    prsb_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .pages    (pages),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_page  (s1_page)
    );

    // Contiguity test and segment state; produces zero, one or two segments.
    prsb_merge #(
        .PAGE_BITS (PAGE_BITS),
        .MAX_PAGES (MAX_PAGES)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_page    (s1_page),
        .room       (room),
        .virt_start (virt_start_reg),
        .virt_end   (virt_end_reg),
        .advance    (advance),
        .push       (push)
    );

    // Decouples the segment consumer from the page producer.
    prsb_out_fifo u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .segs  (segs)
    );

endmodule

`default_nettype wire

@@ hdl/prsb_checker.sv @@
`default_nettype none

`include "page_run_segment_builder_assert.svh"

module prsb_checker import prsb_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [ADDR_W-1:0] seg_virt_begin,
    input wire logic [ADDR_W-1:0] seg_virt_stop,
    input wire logic [ADDR_W-1:0] seg_phys_begin,
    input wire logic [IDX_W-1:0]  first_page_idx,
    input wire logic [IDX_W-1:0]  last_page_idx,
    input wire logic [IDX_W-1:0]  seg_number,
    input wire logic              final_segment
);

    localparam logic SMALL_BUF = (MAX_PAGES <= (2 ** IDX_W));

    // Nothing can be pending while reset is applied.
    `PRSB_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "segment valid during reset")

    // A segment closed by a break ends on a page boundary.
    `PRSB_ASSERT(a_stop_aligned, out_valid && !final_segment |-> seg_virt_stop[PAGE_BITS-1:0] == '0, "non-final segment stop not page aligned")

    // Page indices of a segment are ordered when they are not truncated.
    `PRSB_ASSERT(a_idx_order, SMALL_BUF && out_valid |-> first_page_idx <= last_page_idx, "segment first page after last page")

    // A stalled segment beat keeps its contents.
    `PRSB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(seg_virt_begin) && $stable(seg_virt_stop) && $stable(seg_phys_begin) && $stable(first_page_idx) && $stable(last_page_idx) && $stable(seg_number) && $stable(final_segment), "stalled segment changed")

endmodule

bind page_run_segment_builder prsb_checker #(
    .PAGE_BITS (PAGE_BITS),
    .MAX_PAGES (MAX_PAGES)
) u_prsb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (segs.valid),
    .out_ready      (segs.ready),
    .seg_virt_begin (segs.seg_virt_begin),
    .seg_virt_stop  (segs.seg_virt_stop),
    .seg_phys_begin (segs.seg_phys_begin),
    .first_page_idx (segs.first_page_idx),
    .last_page_idx  (segs.last_page_idx),
    .seg_number     (segs.seg_number),
    .final_segment  (segs.final_segment)
);

`default_nettype wire
